// ===== hdl/lsc_pkg.sv =====
`default_nettype none

package lsc_pkg;

    // Trace geometry
    localparam int NUM_STAGES = 5;
    localparam int STAGE_W    = 3;
    localparam int TIME_W     = 64;
    localparam int ID_W       = 32;
    localparam int KIND_W     = 2;

    localparam logic [STAGE_W-1:0] STAGE_LIMIT = STAGE_W'(NUM_STAGES);

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_BEGIN   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MEASURE = 2'd2;

    // Result status codes
    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_ARG     = 3'd1,
        ST_DUP     = 3'd2,
        ST_ORDER   = 3'd3,
        ST_TIME    = 3'd4,
        ST_MISSING = 3'd5
    } status_t;

    typedef logic [NUM_STAGES-1:0] mask_t;
    typedef logic [NUM_STAGES-1:0][TIME_W-1:0] stamp_arr_t;

    // Input item
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [STAGE_W-1:0] stage;
        logic [STAGE_W-1:0] end_stage;
        logic [TIME_W-1:0]  stamp;
        logic [ID_W-1:0]    trace_id;
    } lsc_in_t;

    // Result item
    typedef struct packed {
        status_t           status;
        logic [TIME_W-1:0] delta;
        mask_t             mask_out;
        logic [ID_W-1:0]   trace_id_out;
    } lsc_out_t;

    // Stamp write from the check stage
    typedef struct packed {
        logic               en;
        logic [STAGE_W-1:0] idx;
        logic [TIME_W-1:0]  data;
    } lsc_wr_t;

    // Stamp read request issued when an item is taken
    typedef struct packed {
        logic               en;
        logic [STAGE_W-1:0] a;
        logic [STAGE_W-1:0] b;
    } lsc_rd_t;

    // Predecessor stages a mark needs
    function automatic mask_t need_mask(input logic [STAGE_W-1:0] s);
        mask_t m;
        case (s)
            3'd0:    m = mask_t'(0);
            3'd1:    m = mask_t'(1);
            3'd2:    m = mask_t'(2);
            default: m = mask_t'(4);
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/latency_stage_trace_checker.sv =====
`default_nettype none

// Latency trace checker: one trace of five stage stamps. Takes one item per
// clock unless a stalled result holds it back, and returns one result per item
// on m_: the item sits in an input register while the stamp file's registered
// read of the start and end stamps completes, then the checks and the
// subtraction run into the result register. State updates land at the edge
// that loads the result and are forwarded, so back-to-back items see the effect
// of their predecessor. A result waiting on m_ready holds the input register,
// after which s_ready drops.
module latency_stage_trace_checker
    import lsc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire lsc_in_t  s_data,
    output logic          m_valid,
    input  wire logic     m_ready,
    output lsc_out_t      m_data
);

    lsc_wr_t           wr;
    lsc_rd_t           rd;
    logic [TIME_W-1:0] rd_a;
    logic [TIME_W-1:0] rd_b;
    stamp_arr_t        stamps;

    lsc_stamp_file u_stamps (
        .aclk   (aclk),
        .wr     (wr),
        .rd     (rd),
        .rd_a   (rd_a),
        .rd_b   (rd_b),
        .stamps (stamps)
    );

    lsc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .rd      (rd),
        .wr      (wr),
        .rd_a    (rd_a),
        .rd_b    (rd_b),
        .stamps  (stamps)
    );

endmodule

`default_nettype wire

// ===== hdl/lsc_stamp_file.sv =====
`default_nettype none

module lsc_stamp_file
    import lsc_pkg::*;
(
    input  wire logic              aclk,
    input  wire lsc_wr_t           wr,
    input  wire lsc_rd_t           rd,
    output logic [TIME_W-1:0]      rd_a,
    output logic [TIME_W-1:0]      rd_b,
    output stamp_arr_t             stamps
);

    stamp_arr_t        stamps_reg;
    logic [TIME_W-1:0] rd_a_reg, rd_a_next;
    logic [TIME_W-1:0] rd_b_reg, rd_b_next;

    // Stamp storage, written by a passing mark
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            stamps_reg[wr.idx] <= wr.data;
        end
    end

    // Selected stamps, with the write of the same edge forwarded
    always_comb begin
        rd_a_next = (rd.a < STAGE_LIMIT) ? stamps_reg[rd.a] : '0;
        rd_b_next = (rd.b < STAGE_LIMIT) ? stamps_reg[rd.b] : '0;
        if (wr.en && wr.idx == rd.a) begin
            rd_a_next = wr.data;
        end
        if (wr.en && wr.idx == rd.b) begin
            rd_b_next = wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd.en) begin
            rd_a_reg <= rd_a_next;
            rd_b_reg <= rd_b_next;
        end
    end

    assign rd_a   = rd_a_reg;
    assign rd_b   = rd_b_reg;
    assign stamps = stamps_reg;

endmodule

`default_nettype wire

// ===== hdl/lsc_core.sv =====
`default_nettype none

module lsc_core
    import lsc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire lsc_in_t           s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output lsc_out_t               m_data,
    output lsc_rd_t                rd,
    output lsc_wr_t                wr,
    input  wire logic [TIME_W-1:0] rd_a,
    input  wire logic [TIME_W-1:0] rd_b,
    input  wire stamp_arr_t        stamps
);

    logic            in_valid_reg;
    lsc_in_t         item_reg;
    logic            out_valid_reg;
    lsc_out_t        out_reg, out_next;
    mask_t           present_reg, present_next;
    logic [ID_W-1:0] id_reg, id_next;

    logic  fire;
    logic  accept;
    mask_t bit_sel;
    mask_t need;
    mask_t late;
    logic  mark_ok;

    // Handshake: input register feeds the check, result register feeds m_
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign accept  = s_valid && s_ready;

    assign rd.en = accept;
    assign rd.a  = s_data.stage;
    assign rd.b  = s_data.end_stage;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    // Mark checks
    assign bit_sel = mask_t'(1) << item_reg.stage;
    assign need    = need_mask(item_reg.stage);

    always_comb begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            late[i] = present_reg[i] && (item_reg.stamp < stamps[i]);
        end
    end

    assign mark_ok = (item_reg.kind == KIND_MARK) && (item_reg.stage < STAGE_LIMIT)
                     && ((present_reg & bit_sel) == '0)
                     && ((present_reg & need) == need) && (late == '0);

    assign wr.en   = fire && mark_ok;
    assign wr.idx  = item_reg.stage;
    assign wr.data = item_reg.stamp;

    // Result and next trace state
    always_comb begin
        present_next = present_reg;
        id_next      = id_reg;
        out_next.status = ST_ARG;
        out_next.delta  = '0;
        case (item_reg.kind)
            KIND_BEGIN: begin
                present_next    = '0;
                id_next         = item_reg.trace_id;
                out_next.status = ST_OK;
            end
            KIND_MARK: begin
                if (item_reg.stage >= STAGE_LIMIT) begin
                    out_next.status = ST_ARG;
                end else if ((present_reg & bit_sel) != '0) begin
                    out_next.status = ST_DUP;
                end else if ((present_reg & need) != need) begin
                    out_next.status = ST_ORDER;
                end else if (late != '0) begin
                    out_next.status = ST_TIME;
                end else begin
                    out_next.status = ST_OK;
                    present_next    = present_reg | bit_sel;
                end
            end
            KIND_MEASURE: begin
                if (item_reg.stage >= STAGE_LIMIT || item_reg.end_stage >= STAGE_LIMIT) begin
                    out_next.status = ST_ARG;
                end else if (!present_reg[item_reg.stage] || !present_reg[item_reg.end_stage]) begin
                    out_next.status = ST_MISSING;
                end else if (rd_b < rd_a) begin
                    out_next.status = ST_TIME;
                end else begin
                    out_next.status = ST_OK;
                    out_next.delta  = rd_b - rd_a;
                end
            end
            default: begin
                out_next.status = ST_ARG;
            end
        endcase
        out_next.mask_out     = present_next;
        out_next.trace_id_out = id_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            present_reg   <= '0;
            id_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (fire) begin
                present_reg   <= present_next;
                id_reg        <= id_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

// ===== hdl/lsc_checker.sv =====
`default_nettype none

module lsc_checker
    import lsc_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    input  wire logic     s_ready,
    input  wire lsc_in_t  s_data,
    input  wire logic     m_valid,
    input  wire logic     m_ready,
    input  wire lsc_out_t m_data
);

    // A stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Only a good measure carries a delta
    a_delta: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.delta == '0)
        else $error("delta on an error result");

    // Stage order holds in the mask
    a_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.mask_out[1] && !m_data.mask_out[0]
                    || m_data.mask_out[2] && !m_data.mask_out[1]
                    || m_data.mask_out[3] && !m_data.mask_out[2]
                    || m_data.mask_out[4] && !m_data.mask_out[2]) |-> 1'b0)
        else $error("stage present without its predecessor");

    // An offered item holds until it is taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_data))
        else $error("input item changed while waiting");

endmodule

bind latency_stage_trace_checker lsc_checker u_lsc_checker (.*);

`default_nettype wire
